// File: rtl/core/mahd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mahd_pkg: shared types and constants of the MPEG audio header decoder
// Bitrate and sample-rate tables, divider sizes, sequencer states.
// ----------------------------------------------------------------------------
package mahd_pkg;

	localparam int unsigned HDR_W    = 32;
	localparam int unsigned OUT_W    = 40;
	localparam int unsigned CFG_W    = 12;
	localparam int unsigned APB_AW   = 2;
	localparam int unsigned KBPS_W   = 9;
	localparam int unsigned HZ_W     = 16;
	localparam int unsigned NUM_W    = 26;   // kbps * 144000 stays below 2**26
	localparam int unsigned DEN_W    = 17;   // sample rate, doubled for layer 3 LSF
	localparam int unsigned QUO_W    = 12;   // frame sizes stay below 4096
	localparam int unsigned CNT_W    = $clog2(QUO_W + 1);

	localparam logic [APB_AW-1:0] REG_FREE_SIZE = 2'd0;

	localparam logic [10:0] SYNC_BITS     = 11'h7ff;
	localparam logic [3:0]  BR_BAD        = 4'd15;
	localparam logic [3:0]  BR_FREE       = 4'd0;
	localparam logic [1:0]  FS_BAD        = 2'd3;
	localparam logic [1:0]  MODE_MONO     = 2'd3;
	localparam logic [1:0]  MODE_STEREO   = 2'd0;
	localparam logic [17:0] K_LAYER1      = 18'd12000;
	localparam logic [17:0] K_LAYER23     = 18'd144000;
	localparam logic [11:0] BODY_MAX      = 12'd4095;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_OUT
	} mahd_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	localparam logic [KBPS_W-1:0] KBPS_TBL [2][3][16] = '{
		'{
			'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
			  9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			  9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
			'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
			  9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
		},
		'{
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			  9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
		}
	};

	// layer index is layer - 1; the unused code reads as zero
	function automatic logic [KBPS_W-1:0] kbps_lookup(input logic lsf,
			input logic [1:0] lidx, input logic [3:0] br);
		logic [KBPS_W-1:0] v;
		v = '0;
		if (lidx != 2'd3) begin
			v = KBPS_TBL[lsf][lidx][br];
		end
		return v;
	endfunction

	function automatic logic [HZ_W-1:0] hz_lookup(input logic [3:0] rate);
		logic [HZ_W-1:0] v;
		case (rate)
			4'd0: v = 16'd44100;
			4'd1: v = 16'd48000;
			4'd2: v = 16'd32000;
			4'd3: v = 16'd22050;
			4'd4: v = 16'd24000;
			4'd5: v = 16'd16000;
			4'd6: v = 16'd11025;
			4'd7: v = 16'd12000;
			4'd8: v = 16'd8000;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/mahd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mahd_div: restoring divider, one quotient bit per cycle
// The quotient is known to fit QUO_W bits, so the upper numerator bits seed
// the remainder and only the low QUO_W bits are shifted through.
// ----------------------------------------------------------------------------
module mahd_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire  [mahd_pkg::NUM_W-1:0]   numer,
	input  wire  [mahd_pkg::DEN_W-1:0]   denom,
	output logic [mahd_pkg::QUO_W-1:0]   quot,
	output mahd_pkg::div_status_t        status
);
	import mahd_pkg::*;

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] qsh_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W+1:0] diff;
	logic             ge;

	assign diff = {1'b0, rem_q, qsh_q[QUO_W-1]} - {2'b00, den_q};
	assign ge   = ~diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(numer[NUM_W-1:QUO_W]);
			qsh_q <= numer[QUO_W-1:0];
			den_q <= denom;
		end else if (busy_q) begin
			// shift the next numerator bit in, subtract when it fits
			rem_q <= ge ? diff[DEN_W-1:0] : {rem_q[DEN_W-2:0], qsh_q[QUO_W-1]};
			qsh_q <= {qsh_q[QUO_W-2:0], ge};
		end
	end

	assign quot   = qsh_q;
	assign status = '{busy: busy_q, done: done_q};

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && $past(cnt_q) == CNT_W'(1))
		else $error("divider done without final step");

endmodule
`default_nettype wire

// File: rtl/core/mpeg_audio_header_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder: MPEG-1/2/2.5 audio frame header parser
// Checks and decodes one 32-bit header, computes frame body and layer-3
// side-info sizes, and compares the format with the last valid header.
//
//   channel | dir | width | contents
//   s_*     | in  | 32    | header word
//   m_*     | out | 40    | decoded fields, sizes, format match
//   apb     | in  | 32    | free-format body size (address 0)
//
// m_tvalid rises after the input transfer once the sequencer has formed the
// numerator kbps * constant, run the bit-serial divider, closed the divide and
// loaded the output register.
// The next header can be taken in the cycle after the load.
// A new header is taken while a finished result still waits on m_tready.
// Reset clears the sequencer, the free-format size and the previous header.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decoder (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire  [mahd_pkg::HDR_W-1:0]     s_tdata,   // header_word
	output logic                           m_tvalid,
	input  wire                            m_tready,
	// valid_res[0] layer[2:1] low_rate[3] is_mpeg25[4] rate_index[8:5]
	// bitrate_code[12:9] pad_flag[13] channel_mode[15:14] crc_present[16]
	// body_bytes[28:17] side_info_bytes[34:29] format_same[35] zero[39:36]
	output logic [mahd_pkg::OUT_W-1:0]     m_tdata,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [mahd_pkg::APB_AW-1:0]    paddr,
	input  wire  [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import mahd_pkg::*;

	mahd_state_t      st_q, st_d;
	logic [HDR_W-1:0] hdr_q;
	logic [CFG_W-1:0] free_size_q;
	logic             seen_q;
	logic [1:0]       prev_fs_q;
	logic             prev_st_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] out_q;

	logic             div_start;
	logic             out_load;
	div_status_t      div_st;
	logic [QUO_W-1:0] quot;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign prdata = (paddr == REG_FREE_SIZE) ? {{(32-CFG_W){1'b0}}, free_size_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_size_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == REG_FREE_SIZE) begin
			free_size_q <= pwdata[CFG_W-1:0];
		end
	end

	// ---------------- header decode ----------------
	logic [1:0]        lb, fs, mode, layer;
	logic [3:0]        br, rate;
	logic              hdr_ok, lsf, m25, pad, crc, l3_lsf;
	logic [KBPS_W-1:0] kbps;
	logic [DEN_W-1:0]  den;
	logic [26:0]       prod;

	always_comb begin
		lb    = hdr_q[18:17];
		br    = hdr_q[15:12];
		fs    = hdr_q[11:10];
		pad   = hdr_q[9];
		mode  = hdr_q[7:6];
		crc   = ~hdr_q[16];
		hdr_ok = (hdr_q[31:21] == SYNC_BITS) && (lb != 2'd0) && (br != BR_BAD)
			&& (fs != FS_BAD);
		if (hdr_q[20]) begin
			m25  = 1'b0;
			lsf  = ~hdr_q[19];
			rate = {2'b00, fs} + (lsf ? 4'd3 : 4'd0);
		end else begin
			m25  = 1'b1;
			lsf  = 1'b1;
			rate = 4'd6 + {2'b00, fs};
		end
		layer  = 2'(3'd4 - {1'b0, lb});
		l3_lsf = (layer == 2'd3) && lsf;
		kbps   = kbps_lookup(lsf, layer - 2'd1, br);
		den    = l3_lsf ? {hz_lookup(rate), 1'b0} : {1'b0, hz_lookup(rate)};
		prod   = kbps * ((layer == 2'd1) ? K_LAYER1 : K_LAYER23);
	end

	mahd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (prod[NUM_W-1:0]),
		.denom  (den),
		.quot   (quot),
		.status (div_st)
	);

	// ---------------- result fields ----------------
	logic [11:0] body, q_pad;
	logic [12:0] free_sum;
	logic [5:0]  side;
	logic        same;
	logic [OUT_W-1:0] pack;

	always_comb begin
		q_pad    = quot + {11'd0, pad};
		free_sum = {1'b0, free_size_q} + ((layer == 2'd1) ? {10'd0, pad, 2'b00}
			: {12'd0, pad});
		if (br == BR_FREE) begin
			body = free_sum[12] ? BODY_MAX : free_sum[11:0];
		end else if (layer == 2'd1) begin
			body = {q_pad[9:0], 2'b00} - 12'd4;
		end else begin
			body = q_pad - 12'd4;
		end
		side = '0;
		if (layer == 2'd3) begin
			if (lsf) begin
				side = (mode == MODE_MONO) ? 6'd9 : 6'd17;
			end else begin
				side = (mode == MODE_MONO) ? 6'd17 : 6'd32;
			end
			if (crc) begin
				side = side + 6'd2;
			end
		end
		same = seen_q && (prev_fs_q == fs) && (prev_st_q == (mode == MODE_STEREO));
		pack = {4'd0, same, side, body, crc, mode, pad, br, rate, m25, lsf, layer, 1'b1};
		if (!hdr_ok) begin
			pack = '0;
		end
	end

	// ---------------- sequencer ----------------
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (s_tvalid) st_d = ST_CALC;
			ST_CALC: st_d = ST_DIV;
			ST_DIV:  if (div_st.done) st_d = ST_OUT;
			ST_OUT:  if (!m_tvalid_q || m_tready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (st_q)
			ST_IDLE: s_tready  = 1'b1;
			ST_CALC: div_start = 1'b1;
			ST_OUT:  out_load  = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			seen_q     <= 1'b0;
			prev_fs_q  <= '0;
			prev_st_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			// remember the last valid header's format
			if (out_load && hdr_ok) begin
				seen_q    <= 1'b1;
				prev_fs_q <= fs;
				prev_st_q <= (mode == MODE_STEREO);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hdr_q <= s_tdata;
		end
		if (out_load) begin
			out_q <= pack;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	a_accept_calc: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> st_q == ST_CALC)
		else $error("transfer did not start a decode");
	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |-> div_st.busy || div_st.done)
		else $error("waiting on an idle divider");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[OUT_W-1:1] == '0)
		else $error("invalid header with nonzero fields");
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |=> seen_q)
		else $error("previous header lost");

endmodule
`default_nettype wire

// File: bench/mpeg_audio_header_decoder_tb.sv
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder_tb: self-checking bench for the audio header decoder
// Walks a directed table of header words, then random headers over several
// free-format sizes. Every untyped result is checked field by field against an
// in-bench decoder that tracks the last valid header and the configured size.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decoder_tb;
	import mahd_pkg::*;

	localparam int unsigned IDLE_LIMIT      = 4000;
	localparam int unsigned PHASES          = 8;
	localparam int unsigned ITEMS_PER_PHASE = 206;
	localparam int unsigned HOLD_AT         = 500;
	localparam int unsigned HOLD_CYCLES     = 300;

	// same bit order as m_tdata, most significant field first
	typedef struct packed {
		logic [3:0]  fill;
		logic        format_same;
		logic [5:0]  side_bytes;
		logic [11:0] body_bytes;
		logic        crc_present;
		logic [1:0]  channel_mode;
		logic        pad_flag;
		logic [3:0]  bitrate_code;
		logic [3:0]  rate_index;
		logic        is_mpeg25;
		logic        low_rate;
		logic [1:0]  layer;
		logic        valid_res;
	} hdr_result_t;

	typedef struct {
		logic [HDR_W-1:0] hdr;
		bit               typed;
		hdr_result_t      res;
	} stim_row_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BUSY
	} rx_mode_t;

	localparam hdr_result_t RES_NONE = '0;
	// MPEG-1 layer 3, 128 kbit/s, 44.1 kHz, joint stereo, first after reset
	localparam hdr_result_t RES_FIRST = '{fill: 4'd0, format_same: 1'b0,
		side_bytes: 6'd32, body_bytes: 12'd413, crc_present: 1'b0,
		channel_mode: 2'd1, pad_flag: 1'b0, bitrate_code: 4'd9,
		rate_index: 4'd0, is_mpeg25: 1'b0, low_rate: 1'b0, layer: 2'd3,
		valid_res: 1'b1};

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [HDR_W-1:0]  s_tdata  = '0;   // header_word
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// valid_res[0] layer[2:1] low_rate[3] is_mpeg25[4] rate_index[8:5]
	// bitrate_code[12:9] pad_flag[13] channel_mode[15:14] crc_present[16]
	// body_bytes[28:17] side_info_bytes[34:29] format_same[35] zero[39:36]
	logic [OUT_W-1:0]  m_tdata;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [APB_AW-1:0] paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic [31:0]       prdata;
	logic              pready;

	mpeg_audio_header_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// kbit/s by [low rate][layer - 1][bitrate index]
	int unsigned kbps_tab [96] = '{
		0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0,
		0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0,
		0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0,
		0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0,
		0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0,
		0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0
	};
	int unsigned hz_tab [9] = '{
		44100, 48000, 32000, 22050, 24000, 16000, 11025, 12000, 8000
	};

	hdr_result_t      expected_frames [$];
	logic [HDR_W-1:0] last_good_hdr = '0;
	logic [CFG_W-1:0] free_size_cfg = '0;
	stim_row_t        dir_tab [23];
	int unsigned      burst_left    = 0;
	int unsigned      sent_cnt      = 0;
	int unsigned      mismatch_cnt  = 0;
	int unsigned      idle_cycles   = 0;
	bit               hold_done     = 1'b0;
	int unsigned      hold_left     = 0;
	int unsigned      mode_left     = 0;
	rx_mode_t         rx_mode       = RX_OPEN;
	logic [1:0]       rx_phase      = '0;
	hdr_result_t      want_r;
	hdr_result_t      got_r;

	function automatic hdr_result_t decode_header(input logic [31:0] h,
			input logic [CFG_W-1:0] ffs, input logic [31:0] prev);
		hdr_result_t r;
		logic [1:0]  lb;
		logic [3:0]  br;
		logic [1:0]  fs;
		logic        lsf;
		int unsigned kbps;
		int unsigned hz;
		int unsigned body;
		int unsigned side;
		int unsigned pad_size;
		r = '0;
		lb = h[18:17];
		br = h[15:12];
		fs = h[11:10];
		if (h[31:21] != SYNC_BITS || lb == 2'd0 || br == BR_BAD || fs == FS_BAD) begin
			return r;
		end
		r.valid_res = 1'b1;
		if (h[20]) begin
			lsf = ~h[19];
			r.is_mpeg25 = 1'b0;
			r.rate_index = {2'b00, fs} + (lsf ? 4'd3 : 4'd0);
		end else begin
			lsf = 1'b1;
			r.is_mpeg25 = 1'b1;
			r.rate_index = 4'd6 + {2'b00, fs};
		end
		r.low_rate = lsf;
		r.layer = 2'd0 - lb;   // 4 minus the layer bits
		r.bitrate_code = br;
		r.pad_flag = h[9];
		r.channel_mode = h[7:6];
		r.crc_present = ~h[16];
		kbps = kbps_tab[int'(lsf) * 48 + (int'(r.layer) - 1) * 16 + int'(br)];
		hz = hz_tab[r.rate_index];
		side = 0;
		case (r.layer)
			2'd1: begin
				body = ((kbps * 12000) / hz + int'(r.pad_flag)) * 4 - 4;
				pad_size = int'(r.pad_flag) * 4;
			end
			2'd2: begin
				body = (kbps * 144000) / hz + int'(r.pad_flag) - 4;
				pad_size = int'(r.pad_flag);
			end
			default: begin
				if (lsf) begin
					side = (r.channel_mode == MODE_MONO) ? 9 : 17;
				end else begin
					side = (r.channel_mode == MODE_MONO) ? 17 : 32;
				end
				if (r.crc_present) begin
					side = side + 2;
				end
				body = (kbps * 144000) / (hz << lsf) + int'(r.pad_flag) - 4;
				pad_size = int'(r.pad_flag);
			end
		endcase
		if (br == BR_FREE) begin
			body = int'(ffs) + pad_size;
			if (body > 4095) begin
				body = 4095;
			end
		end
		r.body_bytes = 12'(body);
		r.side_bytes = 6'(side);
		if (prev != '0 && prev[11:10] == h[11:10] &&
				((prev[7:6] == MODE_STEREO) == (h[7:6] == MODE_STEREO))) begin
			r.format_same = 1'b1;
		end
		return r;
	endfunction

	// mostly well-formed headers, some with one field broken, some raw noise
	function automatic logic [31:0] gen_header();
		logic [31:0] h;
		int unsigned pick;
		h = $urandom();
		pick = $urandom_range(0, 99);
		if (pick >= 10) begin
			h[31:21] = SYNC_BITS;
			if (h[18:17] == 2'd0) begin
				h[18:17] = 2'($urandom_range(1, 3));
			end
			h[15:12] = 4'($urandom_range(0, 14));
			h[11:10] = 2'($urandom_range(0, 2));
			if (pick < 22) begin
				case ($urandom_range(0, 3))
					0: h[21 + $urandom_range(0, 10)] = 1'b0;
					1: h[18:17] = 2'd0;
					2: h[15:12] = BR_BAD;
					default: h[11:10] = FS_BAD;
				endcase
			end
		end
		return h;
	endfunction

	task automatic send_header(input logic [31:0] h, input bit typed,
			input hdr_result_t res);
		int unsigned gap;
		hdr_result_t r;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tdata <= h;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = decode_header(h, free_size_cfg, last_good_hdr);
		if (r.valid_res) begin
			last_good_hdr = h;
		end
		expected_frames.push_back(typed ? res : r);
		sent_cnt++;
		burst_left--;
	endtask

	// drop valid and hold until every pending frame result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_free_size(input logic [CFG_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_FREE_SIZE;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		free_size_cfg = v;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_r = m_tdata;
			if (expected_frames.size() == 0) begin
				$display("%0t: unexpected result transfer, expected none got %0h",
					$time, m_tdata);
				mismatch_cnt++;
			end else begin
				want_r = expected_frames.pop_front();
				check_field("valid_res", want_r.valid_res, got_r.valid_res);
				check_field("layer", want_r.layer, got_r.layer);
				check_field("low_rate", want_r.low_rate, got_r.low_rate);
				check_field("is_mpeg25", want_r.is_mpeg25, got_r.is_mpeg25);
				check_field("rate_index", want_r.rate_index, got_r.rate_index);
				check_field("bitrate_code", want_r.bitrate_code, got_r.bitrate_code);
				check_field("pad_flag", want_r.pad_flag, got_r.pad_flag);
				check_field("channel_mode", want_r.channel_mode, got_r.channel_mode);
				check_field("crc_present", want_r.crc_present, got_r.crc_present);
				check_field("body_bytes", want_r.body_bytes, got_r.body_bytes);
				check_field("side_info_bytes", want_r.side_bytes, got_r.side_bytes);
				check_field("format_same", want_r.format_same, got_r.format_same);
				check_field("zero fill", want_r.fill, got_r.fill);
			end
		end
	end

	// receiver: random ready patterns, plus one long hold-off to back up the input
	always @(posedge clk) begin
		if (!hold_done && sent_cnt >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(32, 256);
			end else begin
				mode_left <= mode_left - 1;
			end
			rx_phase <= rx_phase + 2'd1;
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= (rx_phase == 2'd0);
				default:   m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int unsigned cfg;
		dir_tab = '{
			'{32'hFFFB9064, 1'b1, RES_FIRST},
			'{32'h00000000, 1'b1, RES_NONE},   // no sync at all
			'{32'hFFFFFFFF, 1'b1, RES_NONE},   // bad bitrate and bad rate
			'{32'hFFF99064, 1'b1, RES_NONE},   // reserved layer
			'{32'h7FFB9064, 1'b1, RES_NONE},   // top sync bit clear
			'{32'hFFDB9064, 1'b1, RES_NONE},   // lowest sync bit clear
			'{32'hFFFBF064, 1'b1, RES_NONE},   // bitrate index 15
			'{32'hFFFB9C64, 1'b1, RES_NONE},   // reserved sample rate
			'{32'hFFFFE000, 1'b0, RES_NONE},
			'{32'hFFFEE200, 1'b0, RES_NONE},
			'{32'hFFFD1800, 1'b0, RES_NONE},
			'{32'hFFFCE8C0, 1'b0, RES_NONE},
			'{32'hFFF3E4C0, 1'b0, RES_NONE},
			'{32'hFFF2E440, 1'b0, RES_NONE},
			'{32'hFFE3E800, 1'b0, RES_NONE},
			'{32'hFFEBE800, 1'b0, RES_NONE},   // 2.5 with bit 19 set
			'{32'hFFE7EA00, 1'b0, RES_NONE},
			'{32'hFFE5E800, 1'b0, RES_NONE},   // largest frame
			'{32'hFFFF0200, 1'b0, RES_NONE},   // free format, layer 1 padding
			'{32'hFFFD0000, 1'b0, RES_NONE},
			'{32'hFFFB02C0, 1'b0, RES_NONE},
			'{32'hFFFB1000, 1'b0, RES_NONE},
			'{32'hFFF51680, 1'b0, RES_NONE}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			send_header(dir_tab[i].hdr, dir_tab[i].typed, dir_tab[i].res);
		end
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			if (p % 4 == 0) begin
				cfg = 4091;
			end else if (p == 1 || p == PHASES - 1) begin
				cfg = 0;
			end else begin
				cfg = $urandom_range(1, 4090);
			end
			write_free_size(CFG_W'(cfg));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_header(gen_header(), 1'b0, RES_NONE);
			end
		end
		drain_results();
		repeat (30) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
